// File: hdl/bfm_pkg.sv
package bfm_pkg;

	localparam int FRAMES      = 64;
	localparam int QUEUE_DEPTH = 128;
	localparam int PIN_BITS    = 16;
	localparam int PAGE_BITS   = 32;
	localparam int CQ_DEPTH    = 2;

	localparam int FRAME_W = $clog2(FRAMES);
	localparam int FCNT_W  = $clog2(FRAMES + 1);
	localparam int QIDX_W  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int SWEEP_W = QCNT_W + 1;
	localparam int CQ_IDX_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

	typedef enum logic {
		OP_REQ = 1'b0,
		OP_REL = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2
	} status_t;

	typedef struct packed {
		op_t                  op;
		logic [PAGE_BITS-1:0] page;
		logic                 dirty;
	} cmd_t;

	typedef struct packed {
		status_t              status;
		logic [FRAME_W-1:0]   frame;
		logic                 hit;
		logic                 fetch;
		logic                 wb;
		logic [PAGE_BITS-1:0] vpage;
	} res_t;

	typedef struct packed {
		logic [PIN_BITS-1:0] pin;
		logic                dirty;
		logic                refm;
	} attr_t;

	localparam int ATTR_W = $bits(attr_t);

endpackage

// File: hdl/buffer_frame_manager_clock.sv
// Channel   Handshake              Words carried
// input     in_valid / in_ready    opcode, page_id, mark_dirty
// output    out_valid / out_ready  status, frame, hit, need_fetch, write_back, victim_page
//
// A word reaches the back end through the front register and the command queue. The back
// end scans the page memory one frame per cycle from frame 0. A miss with no free frame
// runs the clock sweep, which pops at most twice the queue occupancy in entries. Reset is
// asynchronous and active low; it empties all queues and frees every frame. While a result
// waits, up to three more words are taken in.
module buffer_frame_manager_clock import bfm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 opcode,
	input  logic [PAGE_BITS-1:0] page_id,
	input  logic                 mark_dirty,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [FRAME_W-1:0]   frame,
	output logic                 hit,
	output logic                 need_fetch,
	output logic                 write_back,
	output logic [PAGE_BITS-1:0] victim_page
);

	logic f_valid;
	logic f_ready;
	cmd_t f_cmd;
	logic b_valid;
	logic b_ready;
	cmd_t b_cmd;
	res_t res;

	// The front stage registers the incoming word and tags its kind.
	bfm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.page_id    (page_id),
		.mark_dirty (mark_dirty),
		.cmd_valid  (f_valid),
		.cmd_ready  (f_ready),
		.cmd        (f_cmd)
	);

	// A short command queue decouples the front from the frame sequencer.
	bfm_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_cmd    (f_cmd),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_cmd   (b_cmd)
	);

	// The back end owns the frame tables, the sweep queue and the result register.
	bfm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd       (b_cmd),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res       (res)
	);

	assign status      = res.status;
	assign frame       = res.frame;
	assign hit         = res.hit;
	assign need_fetch  = res.fetch;
	assign write_back  = res.wb;
	assign victim_page = res.vpage;

endmodule

// File: hdl/bfm_ram.sv
module bfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/bfm_front.sv
module bfm_front import bfm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 opcode,
	input  logic [PAGE_BITS-1:0] page_id,
	input  logic                 mark_dirty,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output cmd_t                 cmd
);

	logic vld_q;
	cmd_t cmd_q;

	assign in_ready  = !vld_q || cmd_ready;
	assign cmd_valid = vld_q;
	assign cmd       = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	// The dirty flag only matters for a release, so it is dropped for requests here.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q.op    <= op_t'(opcode);
			cmd_q.page  <= page_id;
			cmd_q.dirty <= mark_dirty && (op_t'(opcode) == OP_REL);
		end
	end

endmodule

// File: hdl/bfm_cmdq.sv
module bfm_cmdq import bfm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_cmd
);

	cmd_t                mem_q [CQ_DEPTH];
	logic [CQ_IDX_W-1:0] wr_q;
	logic [CQ_IDX_W-1:0] rd_q;
	logic [CQ_CNT_W-1:0] cnt_q;
	logic                push;
	logic                pop;

	assign in_ready  = cnt_q != CQ_CNT_W'(CQ_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_cmd   = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == CQ_IDX_W'(CQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == CQ_IDX_W'(CQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_cmd;
		end
	end

endmodule

// File: hdl/bfm_back.sv
module bfm_back import bfm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_LOOK = 7'b0000010,
		S_SWRD = 7'b0000100,
		S_SWQ  = 7'b0001000,
		S_SWA  = 7'b0010000,
		S_SWP  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t               state_q;
	cmd_t                 cmd_q;
	res_t                 res_q;
	logic [FRAME_W-1:0]   idx_q;
	logic [FRAME_W-1:0]   vf_q;
	logic                 vdirty_q;
	logic [FRAMES-1:0]    valid_q;
	logic [FCNT_W-1:0]    free_cnt_q;
	logic [QIDX_W-1:0]    q_head_q;
	logic [QCNT_W-1:0]    q_cnt_q;
	logic [SWEEP_W-1:0]   sw_n_q;
	logic [SWEEP_W-1:0]   sw_lim_q;

	logic                 pg_we;
	logic [FRAME_W-1:0]   pg_waddr;
	logic [FRAME_W-1:0]   pg_raddr;
	logic [PAGE_BITS-1:0] pg_rdata;
	logic                 at_we;
	logic [FRAME_W-1:0]   at_waddr;
	attr_t                at_wdata;
	logic [FRAME_W-1:0]   at_raddr;
	logic [ATTR_W-1:0]    at_rdata;
	logic                 qu_we;
	logic [FRAME_W-1:0]   qu_wdata;
	logic [FRAME_W-1:0]   qu_rdata;

	attr_t                cur;
	logic                 look_match;
	logic                 look_last;
	logic [PIN_BITS-1:0]  pin_inc;
	logic [PIN_BITS-1:0]  pin_dec;
	logic                 rel_push;
	logic                 push_ok;
	logic [QCNT_W:0]      tail_sum;
	logic [QIDX_W-1:0]    tail;
	logic [QIDX_W-1:0]    head_next;
	logic [FRAME_W-1:0]   free_top;
	logic                 sw_more;

	assign cur        = attr_t'(at_rdata);
	assign look_match = valid_q[idx_q] && (pg_rdata == cmd_q.page);
	assign look_last  = idx_q == FRAME_W'(FRAMES - 1);
	assign pin_inc    = (cur.pin == PIN_MAX) ? cur.pin : cur.pin + 1'b1;
	assign pin_dec    = (cur.pin != '0) ? cur.pin - 1'b1 : cur.pin;
	assign rel_push   = cur.pin == PIN_BITS'(1);
	assign push_ok    = q_cnt_q < QCNT_W'(QUEUE_DEPTH);
	assign tail_sum   = (QCNT_W + 1)'(q_head_q) + (QCNT_W + 1)'(q_cnt_q);
	assign tail       = (tail_sum >= (QCNT_W + 1)'(QUEUE_DEPTH))
		? QIDX_W'(tail_sum - (QCNT_W + 1)'(QUEUE_DEPTH)) : QIDX_W'(tail_sum);
	assign head_next  = (q_head_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : q_head_q + 1'b1;
	assign free_top   = FRAME_W'(free_cnt_q - 1'b1);
	assign sw_more    = (sw_n_q < sw_lim_q) && (q_cnt_q != '0);

	assign cmd_ready = state_q == S_IDLE;
	assign res_valid = state_q == S_OUT;
	assign res       = res_q;

	bfm_ram #(.WIDTH(PAGE_BITS), .DEPTH(FRAMES)) u_page_ram (
		.clk   (clk),
		.we    (pg_we),
		.waddr (pg_waddr),
		.wdata (cmd_q.page),
		.raddr (pg_raddr),
		.rdata (pg_rdata)
	);

	bfm_ram #(.WIDTH(ATTR_W), .DEPTH(FRAMES)) u_attr_ram (
		.clk   (clk),
		.we    (at_we),
		.waddr (at_waddr),
		.wdata (at_wdata),
		.raddr (at_raddr),
		.rdata (at_rdata)
	);

	bfm_ram #(.WIDTH(FRAME_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
		.clk   (clk),
		.we    (qu_we),
		.waddr (tail),
		.wdata (qu_wdata),
		.raddr (q_head_q),
		.rdata (qu_rdata)
	);

	// Memory port control. Read addresses are issued ahead of use, as the memories register their read data.
	always_comb begin
		pg_we    = 1'b0;
		pg_waddr = idx_q;
		pg_raddr = idx_q;
		at_we    = 1'b0;
		at_waddr = idx_q;
		at_wdata = '{pin: PIN_BITS'(1), dirty: 1'b0, refm: 1'b1};
		at_raddr = idx_q;
		qu_we    = 1'b0;
		qu_wdata = idx_q;
		case (state_q)
			S_IDLE: begin
				pg_raddr = '0;
				at_raddr = '0;
			end
			S_LOOK: begin
				if (look_match) begin
					at_we = 1'b1;
					if (cmd_q.op == OP_REQ) begin
						at_wdata = '{pin: pin_inc, dirty: cur.dirty, refm: 1'b1};
					end else begin
						at_wdata = '{pin: pin_dec, dirty: cur.dirty || cmd_q.dirty,
							refm: cur.refm};
						qu_we = rel_push && push_ok;
					end
				end else if (!look_last) begin
					pg_raddr = idx_q + 1'b1;
					at_raddr = idx_q + 1'b1;
				end else if (cmd_q.op == OP_REQ && free_cnt_q != '0) begin
					pg_we    = 1'b1;
					pg_waddr = free_top;
					at_we    = 1'b1;
					at_waddr = free_top;
				end
			end
			S_SWQ: begin
				at_raddr = qu_rdata;
			end
			S_SWA: begin
				if (cur.pin == '0 && cur.refm) begin
					at_we    = 1'b1;
					at_waddr = vf_q;
					at_wdata = '{pin: cur.pin, dirty: cur.dirty, refm: 1'b0};
					qu_we    = push_ok;
					qu_wdata = vf_q;
				end else if (cur.pin == '0) begin
					pg_raddr = vf_q;
				end
			end
			S_SWP: begin
				pg_we    = 1'b1;
				pg_waddr = vf_q;
				at_we    = 1'b1;
				at_waddr = vf_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			valid_q    <= '0;
			free_cnt_q <= FCNT_W'(FRAMES);
			q_head_q   <= '0;
			q_cnt_q    <= '0;
			cmd_q      <= '0;
			res_q      <= '0;
			idx_q      <= '0;
			vf_q       <= '0;
			vdirty_q   <= 1'b0;
			sw_n_q     <= '0;
			sw_lim_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						idx_q   <= '0;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (look_match) begin
						res_q <= '{status: ST_OK, frame: idx_q, hit: cmd_q.op == OP_REQ,
							fetch: 1'b0, wb: 1'b0, vpage: '0};
						if (cmd_q.op == OP_REL && rel_push && push_ok) begin
							q_cnt_q <= q_cnt_q + 1'b1;
						end
						state_q <= S_OUT;
					end else if (!look_last) begin
						idx_q <= idx_q + 1'b1;
					end else if (cmd_q.op == OP_REL) begin
						res_q <= '{status: ST_ABSENT, frame: '0, hit: 1'b0, fetch: 1'b0,
							wb: 1'b0, vpage: '0};
						state_q <= S_OUT;
					end else if (free_cnt_q != '0) begin
						free_cnt_q        <= free_cnt_q - 1'b1;
						valid_q[free_top] <= 1'b1;
						res_q <= '{status: ST_OK, frame: free_top, hit: 1'b0, fetch: 1'b1,
							wb: 1'b0, vpage: '0};
						state_q           <= S_OUT;
					end else begin
						res_q <= '{status: ST_OK, frame: '0, hit: 1'b0, fetch: 1'b0,
							wb: 1'b0, vpage: '0};
						sw_lim_q <= {q_cnt_q, 1'b0};
						sw_n_q   <= '0;
						state_q  <= S_SWRD;
					end
				end
				S_SWRD: begin
					if (sw_more) begin
						q_head_q <= head_next;
						q_cnt_q  <= q_cnt_q - 1'b1;
						sw_n_q   <= sw_n_q + 1'b1;
						state_q  <= S_SWQ;
					end else begin
						res_q.status <= ST_FULL;
						state_q      <= S_OUT;
					end
				end
				S_SWQ: begin
					vf_q    <= qu_rdata;
					state_q <= S_SWA;
				end
				S_SWA: begin
					if (cur.pin != '0) begin
						state_q <= S_SWRD;
					end else if (cur.refm) begin
						if (push_ok) begin
							q_cnt_q <= q_cnt_q + 1'b1;
						end
						state_q <= S_SWRD;
					end else begin
						vdirty_q <= cur.dirty;
						state_q  <= S_SWP;
					end
				end
				S_SWP: begin
					res_q.frame <= vf_q;
					res_q.fetch <= 1'b1;
					res_q.wb    <= vdirty_q;
					res_q.vpage <= vdirty_q ? pg_rdata : '0;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_qcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("sweep queue count beyond depth");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= FCNT_W'(FRAMES))
		else $error("free count beyond frame count");

	a_sweep_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWRD) |-> (free_cnt_q == '0))
		else $error("sweep started with free frames left");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && res_q.status != ST_OK) |->
		(res_q.frame == '0 && !res_q.hit && !res_q.fetch && !res_q.wb))
		else $error("failed result carries data");

endmodule
